### design/assert_macros.svh
// assertion macros shared by the glyph transform rtl
// no dependencies; checks compile out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### design/g8t_pkg.sv
// types and constants for the 8x8 glyph transform
// no dependencies
package g8t_pkg;

  localparam int GLYPH_ROWS = 8;
  localparam int ROW_W      = 8;
  localparam int OP_W       = 4;

  typedef enum logic [OP_W-1:0] {
    OP_PASS       = 4'd0,
    OP_CLEAR      = 4'd1,
    OP_INVERT     = 4'd2,
    OP_HMIRROR    = 4'd3,
    OP_VMIRROR    = 4'd4,
    OP_ROTATE     = 4'd5,
    OP_ROLL_LEFT  = 4'd6,
    OP_ROLL_RIGHT = 4'd7,
    OP_ROLL_UP    = 4'd8,
    OP_ROLL_DOWN  = 4'd9
  } op_t;

  typedef logic [GLYPH_ROWS-1:0][ROW_W-1:0] glyph_t;

  typedef struct packed {
    logic [OP_W-1:0]  req_type;
    logic [ROW_W-1:0] row0;
    logic [ROW_W-1:0] row1;
    logic [ROW_W-1:0] row2;
    logic [ROW_W-1:0] row3;
    logic [ROW_W-1:0] row4;
    logic [ROW_W-1:0] row5;
    logic [ROW_W-1:0] row6;
    logic [ROW_W-1:0] row7;
  } g8t_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row0;
    logic [ROW_W-1:0] out_row1;
    logic [ROW_W-1:0] out_row2;
    logic [ROW_W-1:0] out_row3;
    logic [ROW_W-1:0] out_row4;
    logic [ROW_W-1:0] out_row5;
    logic [ROW_W-1:0] out_row6;
    logic [ROW_W-1:0] out_row7;
  } g8t_out_t;

endpackage

### design/glyph_8x8_transform_top.sv
// 8x8 glyph transform: input register, transform mux, result register
// depends on g8t_pkg and assert_macros.svh
// throughput: one word per cycle; busy is held low, nothing stalls
// the receiver cannot stall, each result shows for one cycle with out_strobe
// reset: synchronous active-low rst_n clears both valid flags, payload unreset
`include "assert_macros.svh"

module glyph_8x8_transform_top
  import g8t_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  g8t_in_t  in_data,
  output logic     out_strobe,
  output g8t_out_t out_data
);

  logic     in_vld_r;
  g8t_in_t  in_r;
  logic     out_vld_r;
  g8t_out_t out_r;
  glyph_t   src;
  glyph_t   res_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
    if (in_vld_r) begin
      out_r.out_row0 <= res_nxt[0];
      out_r.out_row1 <= res_nxt[1];
      out_r.out_row2 <= res_nxt[2];
      out_r.out_row3 <= res_nxt[3];
      out_r.out_row4 <= res_nxt[4];
      out_r.out_row5 <= res_nxt[5];
      out_r.out_row6 <= res_nxt[6];
      out_r.out_row7 <= res_nxt[7];
    end
  end

  always_comb begin
    src[0] = in_r.row0;
    src[1] = in_r.row1;
    src[2] = in_r.row2;
    src[3] = in_r.row3;
    src[4] = in_r.row4;
    src[5] = in_r.row5;
    src[6] = in_r.row6;
    src[7] = in_r.row7;
  end

  always_comb begin
    res_nxt = src;
    case (in_r.req_type)
      OP_CLEAR: begin
        res_nxt = '0;
      end
      OP_INVERT: begin
        res_nxt = ~src;
      end
      OP_HMIRROR: begin
        for (int i = 0; i < GLYPH_ROWS; i++) begin
          for (int b = 0; b < ROW_W; b++) begin
            res_nxt[i][b] = src[i][ROW_W-1-b];
          end
        end
      end
      OP_VMIRROR: begin
        for (int i = 0; i < GLYPH_ROWS; i++) begin
          res_nxt[i] = src[GLYPH_ROWS-1-i];
        end
      end
      OP_ROTATE: begin
        for (int j = 0; j < GLYPH_ROWS; j++) begin
          for (int k = 0; k < GLYPH_ROWS; k++) begin
            res_nxt[j][ROW_W-1-k] = src[k][j];
          end
        end
      end
      OP_ROLL_LEFT: begin
        for (int i = 0; i < GLYPH_ROWS; i++) begin
          res_nxt[i] = {src[i][ROW_W-2:0], src[i][ROW_W-1]};
        end
      end
      OP_ROLL_RIGHT: begin
        for (int i = 0; i < GLYPH_ROWS; i++) begin
          res_nxt[i] = {src[i][0], src[i][ROW_W-1:1]};
        end
      end
      OP_ROLL_UP: begin
        for (int i = 0; i < GLYPH_ROWS; i++) begin
          res_nxt[i] = src[3'(i + 1)];
        end
      end
      OP_ROLL_DOWN: begin
        for (int i = 0; i < GLYPH_ROWS; i++) begin
          res_nxt[i] = src[3'(i + GLYPH_ROWS - 1)];
        end
      end
      default: begin
        res_nxt = src;
      end
    endcase
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

  `ASSERT_PROP(a_accept_loads, clk, rst_n, start |=> in_vld_r, "accepted word not registered")
  `ASSERT_PROP(a_strobe_follows, clk, rst_n, in_vld_r |=> out_strobe, "result strobe missing")
  `ASSERT_PROP(a_no_spurious, clk, rst_n, !in_vld_r |=> !out_strobe, "result strobe invented")
  `ASSERT_PROP(a_clear_zero, clk, rst_n, (in_vld_r && in_r.req_type == OP_CLEAR) |=> (out_data == '0), "clear result not zero")
  `ASSERT_PROP(a_invert_row0, clk, rst_n, (in_vld_r && in_r.req_type == OP_INVERT) |=> (out_data.out_row0 == ~$past(in_r.row0)), "invert result wrong")
  `ASSERT_NEVER(a_never_busy, clk, rst_n, busy, "busy raised")

endmodule
